### design/tzr_pkg.sv
// Shared types, constants and the shade character table for the torus renderer.
package tzr_pkg;

  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 22;
  localparam int DEF_TUBE_STEPS = 324;
  localparam int DEF_RING_STEPS = 90;

  localparam int TUBE_W = 9;
  localparam int RING_W = 7;
  localparam int RECIP_SH = 20;

  localparam logic signed [31:0] DEPTH_K = 32'sd5242880;
  localparam logic signed [31:0] NORM_K = 32'sd3145728;
  localparam logic signed [33:0] CENTER_X = 34'sd40;
  localparam logic signed [33:0] CENTER_Y = 34'sd12;
  localparam logic signed [12:0] SCALE_X = 13'sd30;
  localparam logic signed [12:0] SCALE_Y = 13'sd15;
  localparam logic signed [13:0] RADIUS_K = 14'sd2048;
  localparam logic signed [11:0] UNIT = 12'sd1024;

  localparam logic signed [12:0] ROT_K_TUBE = 13'sd5;
  localparam logic signed [12:0] ROT_K_RING = 13'sd9;
  localparam logic signed [12:0] ROT_K_A = 13'sd5;
  localparam logic signed [12:0] ROT_K_B = 13'sd5;

  localparam logic [3:0] SHADE_MAX = 4'd11;
  localparam logic [3:0] BLANK_CODE = 4'd15;
  localparam logic [7:0] DEPTH_BLANK = 8'd127;
  localparam logic [6:0] CHAR_NEWLINE = 7'd10;
  localparam logic [6:0] CHAR_SPACE = 7'd32;
  localparam logic [6:0] CHAR_NONE = 7'd0;

  localparam logic [4:0] PLOT_LAST = 5'd20;
  localparam logic [4:0] ROT_LAST = 5'd7;
  localparam logic [4:0] READ_LAST = 5'd2;

  typedef struct packed {
    logic action;
    logic [10:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic plotted;
    logic frame_end;
  } result_t;

  typedef struct packed {
    logic start;
    logic signed [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [32:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_PLOT, ST_DIVX, ST_DIVY,
    ST_CHECK, ST_ADDR, ST_FETCH, ST_TEST, ST_ROT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {ROT_TUBE, ROT_RING, ROT_A, ROT_B} rot_sel_t;

  function automatic logic [6:0] shade_char(input logic [3:0] sc);
    logic [6:0] ch;
    case (sc)
      4'd0: ch = 7'd46;
      4'd1: ch = 7'd44;
      4'd2: ch = 7'd45;
      4'd3: ch = 7'd126;
      4'd4: ch = 7'd58;
      4'd5: ch = 7'd59;
      4'd6: ch = 7'd61;
      4'd7: ch = 7'd33;
      4'd8: ch = 7'd42;
      4'd9: ch = 7'd35;
      4'd10: ch = 7'd36;
      4'd11: ch = 7'd64;
      default: ch = CHAR_SPACE;
    endcase
    return ch;
  endfunction

endpackage

### design/tzr_mul.sv
// Shared signed multiplier with a registered product.
module tzr_mul (
  input logic clk,
  input logic signed [12:0] a,
  input logic signed [31:0] b,
  output logic signed [44:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

### design/tzr_div.sv
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
module tzr_div (
  input logic clk,
  input logic rst,
  input tzr_pkg::div_req_t req,
  output tzr_pkg::div_rsp_t rsp
);
  import tzr_pkg::*;

  logic [32:0] r;
  logic [31:0] q;
  logic [31:0] den;
  logic [5:0] cnt;
  logic neg;
  logic busy;
  logic done;
  logic [32:0] r_sh;

  assign r_sh = {r[31:0], q[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= req.num[31];
        q <= req.num[31] ? 32'(-req.num) : req.num;
        den <= req.den;
        r <= '0;
        cnt <= 6'd32;
        busy <= 1'b1;
      end else if (busy) begin
        if (r_sh >= {1'b0, den}) begin
          r <= r_sh - {1'b0, den};
          q <= {q[30:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end
endmodule

### design/torus_zbuffer_raster_top.sv
// Top level of the spinning torus text renderer: sequencer, datapath and cell store.
// The input channel carries one item per handshake: a plot tick or a read of one cell.
// Every item gives exactly one result item on the output channel.
// A plot tick runs 21 plot steps, two divisions when the point is in front of the
// viewer, a store lookup when it lands on screen, and one to four rotations.
// A read takes two multiplier steps for the newline test and a store update.
// All arithmetic runs through one shared multiplier and one serial divider,
// and item_stall stays high while an item is in work.
// After reset the block sweeps the cell store once, one cell per cycle, over all
// SCREEN_COLS * SCREEN_ROWS cells (1760 by default) before it takes items.
// The result sits in an output register; the next item is accepted while it
// waits, but a finished result waits for that register while the receiver stalls.
module torus_zbuffer_raster_top #(
  parameter int SCREEN_COLS = tzr_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tzr_pkg::DEF_SCREEN_ROWS,
  parameter int TUBE_STEPS = tzr_pkg::DEF_TUBE_STEPS,
  parameter int RING_STEPS = tzr_pkg::DEF_RING_STEPS
) (
  input logic clk,
  input logic rst,
  input logic item_valid,
  output logic item_stall,
  input tzr_pkg::item_t item,
  output logic result_valid,
  input logic result_stall,
  output tzr_pkg::result_t result
);
  import tzr_pkg::*;

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW = $clog2(CELLS);
  localparam logic signed [31:0] RECIP_COLS =
    32'(((1 << RECIP_SH) + SCREEN_COLS - 1) / SCREEN_COLS);

  state_t state, state_next;
  rot_sel_t rot_sel;
  logic [4:0] step;
  logic [AW-1:0] clr;

  logic signed [11:0] sa, ca, sb, cb, sr, cr, st, ct;
  logic [TUBE_W-1:0] tube_step;
  logic [RING_W-1:0] ring_step;
  logic [TUBE_W-1:0] tube_inc;
  logic [RING_W-1:0] ring_inc;
  logic tube_wrap, ring_wrap;

  logic signed [31:0] x1, x2, x3, x4, x5, x6, x7, u, v, w, q, numx, numy, acc;
  logic signed [11:0] nc, ns;
  logic signed [12:0] g;
  logic signed [33:0] px, py;
  logic [3:0] n_shade;
  logic [7:0] zz;
  logic [10:0] idx;
  logic idx_in;
  logic accept;
  logic in_range;
  logic win;

  logic signed [13:0] x0;
  logic signed [31:0] p10, p32, nfull, zfull, addr_sum;
  logic signed [11:0] rot_d, c_cur, s_cur, p10w;
  logic signed [12:0] rot_k;

  logic signed [12:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [44:0] prod;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [11:0] mem [CELLS];
  logic [AW-1:0] mem_addr;
  logic [11:0] mem_q;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [11:0] mem_wd;

  logic [6:0] char_r;
  logic plotted_r, fend_r;

  tzr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  tzr_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign accept = item_valid && !item_stall;
  assign x0 = 14'(cr) + RADIUS_K;
  assign p10 = 32'(prod >>> 10);
  assign p32 = 32'(prod);
  assign p10w = 12'(prod >>> 10);
  assign nfull = (((w >>> 10) - x5) >>> 7);
  assign zfull = (x6 - DEPTH_K) >>> 15;
  assign addr_sum = p32 + 32'(px);
  assign idx_in = 32'(idx) < 32'(CELLS);
  assign in_range = (px > 34'sd0) && (px < 34'(SCREEN_COLS)) &&
                    (py > 34'sd0) && (py < 34'(SCREEN_ROWS));
  assign win = $signed(zz) < $signed(mem_q[7:0]);
  assign tube_inc = tube_step + 1'b1;
  assign ring_inc = ring_step + 1'b1;
  assign tube_wrap = ({1'b0, tube_inc} >= (TUBE_W + 1)'(TUBE_STEPS)) || (tube_inc == '0);
  assign ring_wrap = ({1'b0, ring_inc} >= (RING_W + 1)'(RING_STEPS)) || (ring_inc == '0);

  always_comb begin
    case (rot_sel)
      ROT_TUBE: begin
        c_cur = ct;
        s_cur = st;
        rot_k = ROT_K_TUBE;
        rot_d = 12'(prod >>> 8);
      end
      ROT_RING: begin
        c_cur = cr;
        s_cur = sr;
        rot_k = ROT_K_RING;
        rot_d = 12'(prod >>> 7);
      end
      ROT_A: begin
        c_cur = ca;
        s_cur = sa;
        rot_k = ROT_K_A;
        rot_d = 12'(prod >>> 7);
      end
      default: begin
        c_cur = cb;
        s_cur = sb;
        rot_k = ROT_K_B;
        rot_d = 12'(prod >>> 8);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == AW'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE: if (accept) state_next = item.action ? ST_READ : ST_PLOT;
      ST_READ: if (step == READ_LAST) state_next = ST_DONE;
      ST_PLOT: if (step == PLOT_LAST) state_next = (x6 > 32'sd0) ? ST_DIVX : ST_ROT;
      ST_DIVX: if (div_rsp.done) state_next = ST_DIVY;
      ST_DIVY: if (div_rsp.done) state_next = ST_CHECK;
      ST_CHECK: state_next = in_range ? ST_ADDR : ST_ROT;
      ST_ADDR: state_next = ST_FETCH;
      ST_FETCH: state_next = ST_TEST;
      ST_TEST: state_next = ST_ROT;
      ST_ROT: begin
        if (step == ROT_LAST) begin
          case (rot_sel)
            ROT_TUBE: state_next = tube_wrap ? ST_ROT : ST_DONE;
            ROT_RING: state_next = ring_wrap ? ST_ROT : ST_DONE;
            ROT_A: state_next = ST_ROT;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_DONE: if (!result_valid || !result_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    div_req = '0;
    mem_we = 1'b0;
    mem_wa = mem_addr;
    mem_wd = {BLANK_CODE, DEPTH_BLANK};
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr;
      end
      ST_IDLE: item_stall = 1'b0;
      ST_READ: begin
        case (step)
          5'd0: begin mul_a = 13'(idx); mul_b = RECIP_COLS; end
          5'd1: begin mul_a = 13'(SCREEN_COLS); mul_b = p32 >>> RECIP_SH; end
          default: mem_we = idx_in;
        endcase
      end
      ST_PLOT: begin
        case (step)
          5'd0: begin mul_a = 13'(ct); mul_b = 32'(x0); end
          5'd1: begin mul_a = 13'(ca); mul_b = 32'(sr); end
          5'd2: begin mul_a = 13'(st); mul_b = 32'(x0); end
          5'd3: begin mul_a = 13'(sa); mul_b = 32'(sr); end
          5'd4: begin mul_a = 13'(sa); mul_b = x3; end
          5'd5: begin mul_a = 13'(ca); mul_b = x3; end
          5'd6: begin mul_a = 13'(cr); mul_b = 32'(st); end
          5'd7: begin mul_a = 13'(cb); mul_b = x1; end
          5'd8: begin mul_a = 13'(sb); mul_b = x4; end
          5'd9: begin mul_a = 13'(cb); mul_b = x4; end
          5'd10: begin mul_a = SCALE_X; mul_b = u; end
          5'd11: begin mul_a = 13'(sb); mul_b = x1; end
          5'd12: begin mul_a = -13'(sa); mul_b = x7; end
          5'd13: begin mul_a = SCALE_Y; mul_b = v; end
          5'd14: begin mul_a = 13'(cb); mul_b = w; end
          5'd15: begin mul_a = -13'(ca); mul_b = x7; end
          5'd16: begin mul_a = 13'(cr); mul_b = 32'(sb); end
          5'd18: begin mul_a = 13'(ct); mul_b = q; end
          5'd20: begin
            if (x6 > 32'sd0) begin
              div_req.start = 1'b1;
              div_req.num = numx;
              div_req.den = x6;
            end
          end
          default: mul_a = '0;
        endcase
      end
      ST_DIVX: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num = numy;
          div_req.den = x6;
        end
      end
      ST_CHECK: begin
        mul_a = 13'(SCREEN_COLS);
        mul_b = 32'(py);
      end
      ST_TEST: begin
        if (win) begin
          mem_we = 1'b1;
          mem_wd = {n_shade, zz};
        end
      end
      ST_ROT: begin
        case (step)
          5'd0: begin mul_a = rot_k; mul_b = 32'(s_cur); end
          5'd1: begin mul_a = rot_k; mul_b = 32'(c_cur); end
          5'd2: begin mul_a = 13'(nc); mul_b = 32'(nc); end
          5'd3: begin mul_a = 13'(ns); mul_b = 32'(ns); end
          5'd5: begin mul_a = g; mul_b = 32'(nc); end
          5'd6: begin mul_a = g; mul_b = 32'(ns); end
          default: mul_a = '0;
        endcase
      end
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      clr <= '0;
      rot_sel <= ROT_TUBE;
      result_valid <= 1'b0;
      sa <= UNIT;
      ca <= '0;
      sb <= UNIT;
      cb <= '0;
      sr <= '0;
      cr <= UNIT;
      st <= '0;
      ct <= UNIT;
      tube_step <= '0;
      ring_step <= '0;
    end else begin
      if (state == ST_DONE && (!result_valid || !result_stall)) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            idx <= item.cell_index;
            mem_addr <= AW'(32'(item.cell_index));
            char_r <= CHAR_NONE;
            plotted_r <= 1'b0;
            fend_r <= 1'b0;
            step <= '0;
            rot_sel <= ROT_TUBE;
          end
        end
        ST_READ: begin
          if (step == READ_LAST) begin
            step <= '0;
            if (p32 == 32'(idx)) char_r <= CHAR_NEWLINE;
            else if (idx_in) char_r <= shade_char(mem_q[11:8]);
            else char_r <= CHAR_NONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_PLOT: begin
          step <= (step == PLOT_LAST) ? 5'd0 : step + 1'b1;
          case (step)
            5'd1: x1 <= p10;
            5'd2: x2 <= p10;
            5'd3: x3 <= p10;
            5'd4: x5 <= p10;
            5'd5: x4 <= x2 - p10;
            5'd6: x6 <= DEPTH_K + (x5 <<< 10) + p32;
            5'd7: x7 <= p10;
            5'd8: u <= p32;
            5'd9: u <= u - p32;
            5'd10: v <= p32;
            5'd11: numx <= p32;
            5'd12: v <= v + p32;
            5'd13: w <= p10 + x2;
            5'd14: numy <= p32;
            5'd15: w <= p32;
            5'd16: w <= p32 - w;
            5'd17: q <= p10;
            5'd19: w <= w - p32;
            5'd20: begin
              zz <= zfull[7:0];
              if (nfull < 32'sd0) n_shade <= 4'd0;
              else if (nfull > 32'(SHADE_MAX)) n_shade <= SHADE_MAX;
              else n_shade <= nfull[3:0];
            end
            default: ;
          endcase
        end
        ST_DIVX: if (div_rsp.done) px <= CENTER_X + 34'(div_rsp.quo);
        ST_DIVY: if (div_rsp.done) py <= CENTER_Y + 34'(div_rsp.quo);
        ST_ADDR: mem_addr <= addr_sum[AW-1:0];
        ST_TEST: if (win) plotted_r <= 1'b1;
        ST_ROT: begin
          step <= (step == ROT_LAST) ? 5'd0 : step + 1'b1;
          case (step)
            5'd1: nc <= c_cur - rot_d;
            5'd2: ns <= s_cur + rot_d;
            5'd3: acc <= NORM_K - p32;
            5'd4: g <= 13'((acc - p32) >>> 11);
            5'd6: begin
              case (rot_sel)
                ROT_TUBE: ct <= p10w;
                ROT_RING: cr <= p10w;
                ROT_A: ca <= p10w;
                default: cb <= p10w;
              endcase
            end
            5'd7: begin
              case (rot_sel)
                ROT_TUBE: begin
                  st <= tube_wrap ? '0 : p10w;
                  tube_step <= tube_wrap ? '0 : tube_inc;
                  if (tube_wrap) begin
                    ct <= UNIT;
                    rot_sel <= ROT_RING;
                  end
                end
                ROT_RING: begin
                  sr <= ring_wrap ? '0 : p10w;
                  ring_step <= ring_wrap ? '0 : ring_inc;
                  if (ring_wrap) begin
                    cr <= UNIT;
                    rot_sel <= ROT_A;
                  end
                end
                ROT_A: begin
                  sa <= p10w;
                  rot_sel <= ROT_B;
                end
                default: begin
                  sb <= p10w;
                  fend_r <= 1'b1;
                end
              endcase
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result.char_code <= char_r;
            result.plotted <= plotted_r;
            result.frame_end <= fend_r;
          end
        end
        default: step <= '0;
      endcase
    end
  end
endmodule

### test/tb_torus_zbuffer_raster_top.sv
// Testbench for the torus renderer: directed and random plot ticks and cell reads checked against a predictor.
`timescale 1ns / 1ps

module tb_torus_zbuffer_raster_top;
  import tzr_pkg::*;

  localparam int COLS = DEF_SCREEN_COLS;
  localparam int ROWS = DEF_SCREEN_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam int WATCH_LIMIT = 40000;
  localparam logic ACT_PLOT = 1'b0;
  localparam logic ACT_READ = 1'b1;

  class torus_scoreboard;
    longint sa, ca, sb, cb, sr, cr, st, ct;
    int tube_cnt, ring_cnt;
    byte shade_mem[CELLS];
    byte depth_mem[CELLS];
    result_t expected_q[$];
    int errors;
    int plots_won, reads_done, ticks_done;

    function new();
      sa = 1024; ca = 0; sb = 1024; cb = 0;
      sr = 0; cr = 1024; st = 0; ct = 1024;
      tube_cnt = 0; ring_cnt = 0;
      foreach (shade_mem[k]) begin
        shade_mem[k] = BLANK_CODE;
        depth_mem[k] = 127;
      end
    endfunction

    function longint wrap12(longint v);
      logic signed [11:0] t;
      t = v[11:0];
      return longint'(t);
    endfunction

    function void spin(longint mul, int sh, ref longint c, ref longint s);
      longint nc, ns, g;
      nc = wrap12(c - ((mul * s) >>> sh));
      ns = wrap12(s + ((mul * c) >>> sh));
      g = (longint'(NORM_K) - nc * nc - ns * ns) >>> 11;
      c = wrap12((nc * g) >>> 10);
      s = wrap12((ns * g) >>> 10);
    endfunction

    function bit project_point();
      longint x0, x1, x2, x3, x4, x5, x6, x7, px, py, n, zz, o;
      logic signed [7:0] z8;
      x0 = cr + 2048;
      x1 = (ct * x0) >>> 10;
      x2 = (ca * sr) >>> 10;
      x3 = (st * x0) >>> 10;
      x4 = x2 - ((sa * x3) >>> 10);
      x5 = (sa * sr) >>> 10;
      x6 = longint'(DEPTH_K) + 1024 * x5 + ca * x3;
      x7 = (cr * st) >>> 10;
      if (x6 <= 0) return 0;
      px = 40 + (30 * (cb * x1 - sb * x4)) / x6;
      py = 12 + (15 * (cb * x4 + sb * x1)) / x6;
      n = ((((-ca * x7 - cb * (((-sa * x7) >>> 10) + x2)
          - ct * ((cr * sb) >>> 10)) >>> 10) - x5) >>> 7);
      zz = (x6 - longint'(DEPTH_K)) >>> 15;
      z8 = zz[7:0];
      if (!(py > 0 && py < ROWS && px > 0 && px < COLS)) return 0;
      o = px + COLS * py;
      if (o >= CELLS || longint'(z8) >= longint'(depth_mem[o])) return 0;
      if (n < 0) n = 0;
      if (n > 11) n = 11;
      depth_mem[o] = z8;
      shade_mem[o] = byte'(n);
      return 1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      byte sc;
      r = '0;
      if (it.action == ACT_READ) begin
        reads_done++;
        if (it.cell_index % COLS == 0) r.char_code = CHAR_NEWLINE;
        if (it.cell_index < CELLS) begin
          sc = shade_mem[it.cell_index];
          if (r.char_code == CHAR_NONE) begin
            case (sc)
              0: r.char_code = 7'd46;
              1: r.char_code = 7'd44;
              2: r.char_code = 7'd45;
              3: r.char_code = 7'd126;
              4: r.char_code = 7'd58;
              5: r.char_code = 7'd59;
              6: r.char_code = 7'd61;
              7: r.char_code = 7'd33;
              8: r.char_code = 7'd42;
              9: r.char_code = 7'd35;
              10: r.char_code = 7'd36;
              11: r.char_code = 7'd64;
              default: r.char_code = CHAR_SPACE;
            endcase
          end
          shade_mem[it.cell_index] = BLANK_CODE;
          depth_mem[it.cell_index] = 127;
        end
      end else begin
        ticks_done++;
        r.plotted = project_point();
        if (r.plotted) plots_won++;
        spin(5, 8, ct, st);
        tube_cnt = (tube_cnt + 1) & 9'h1FF;
        if (tube_cnt >= DEF_TUBE_STEPS || tube_cnt == 0) begin
          tube_cnt = 0;
          st = 0; ct = 1024;
          spin(9, 7, cr, sr);
          ring_cnt = (ring_cnt + 1) & 7'h7F;
          if (ring_cnt >= DEF_RING_STEPS || ring_cnt == 0) begin
            ring_cnt = 0;
            sr = 0; cr = 1024;
            spin(5, 7, ca, sa);
            spin(5, 8, cb, sb);
            r.frame_end = 1;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.char_code !== want.char_code || got.plotted !== want.plotted ||
          got.frame_end !== want.frame_end) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected char=%0d plotted=%0d frame_end=%0d, got %0d %0d %0d",
                   want.char_code, want.plotted, want.frame_end,
                   got.char_code, got.plotted, got.frame_end);
      end
    endfunction
  endclass

  logic clk, rst;
  logic item_valid, item_stall, result_valid, result_stall;
  item_t item;
  result_t result;
  torus_scoreboard board;
  int send_idle_pct, recv_stall_pct, quiet_cycles;

  torus_zbuffer_raster_top dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result);
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
      $display("[torus_zbuffer_raster_top] ERROR");
      $finish;
    end
  end

  task automatic send(logic act, logic [10:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 0;
      @(negedge clk);
    end
    item_valid = 1;
    item.action = act;
    item.cell_index = idx;
    do @(posedge clk); while (item_stall);
    board.note_item(item);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid = 0;
    while (board.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_items(int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 60) send(ACT_PLOT, 11'($urandom));
      else if ($urandom_range(1)) send(ACT_READ, 11'($urandom_range(2047)));
      else send(ACT_READ, 11'($urandom_range(18, 4) * COLS + $urandom_range(65, 15)));
    end
  endtask

  initial begin
    int k;
    board = new();
    rst = 1;
    item_valid = 0;
    item = '0;
    result_stall = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(ACT_READ, 11'd0);
    send(ACT_READ, 11'd1);
    send(ACT_READ, 11'd79);
    send(ACT_READ, 11'd80);
    send(ACT_READ, 11'(CELLS - 1));
    send(ACT_READ, 11'(CELLS));
    send(ACT_READ, 11'(CELLS + COLS));
    send(ACT_READ, 11'd2047);
    for (k = 0; k < 10; k++) send(ACT_PLOT, 11'h7FF);
    send(ACT_READ, 11'(12 * COLS + 40));
    send(ACT_READ, 11'(12 * COLS + 70));
    send(ACT_READ, 11'(13 * COLS));
    drain();

    random_items(350);
    send_idle_pct = 81;
    random_items(350);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 81;
    random_items(350);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    random_items(350);
    drain();
    repeat (300) @(posedge clk);

    board.errors += board.expected_q.size();
    $display("covered %0d plot ticks (%0d won the depth test) and %0d cell reads,",
             board.ticks_done, board.plots_won, board.reads_done);
    $display("under free flow, sender gaps, receiver stalls and light mixed pressure");
    if (board.errors == 0)
      $display("[torus_zbuffer_raster_top] OK");
    else
      $display("[torus_zbuffer_raster_top] ERROR");
    $finish;
  end

endmodule
